// ===== rtl/lqm_pkg.sv =====
// ----------------------------------------------------------------------------
// Linked queue manager package
// Shared sizes, request and status codes, item types and the controller's
// state and link memory command types.
// ----------------------------------------------------------------------------
package lqm_pkg;

    localparam int NUM_ELEMS  = 16;
    localparam int NUM_QUEUES = 4;

    localparam int REQ_W  = 2;
    localparam int QSEL_W = 2;
    localparam int ELEM_W = 4;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 5;

    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;

    localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_QUEUED = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [QSEL_W-1:0] queue_sel;
        logic [ELEM_W-1:0] elem_index;
    } in_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  queue_length;
        logic [ELEM_W-1:0] head_elem;
        logic              head_valid;
    } out_t;

    typedef struct packed {
        logic              we;
        logic [ELEM_W-1:0] waddr;
        logic [ELEM_W-1:0] wdata;
        logic [ELEM_W-1:0] raddr;
    } ram_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_APP_TAIL,
        S_APP_LINK,
        S_REM_LINK,
        S_RESP
    } state_t;

endpackage

// ===== rtl/lqm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module lqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lqm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Linked queue manager controller
// Request sequencer that holds the membership, owner, head and length tables
// and drives the next and prev link memories.
// ----------------------------------------------------------------------------
module lqm_ctrl
    import lqm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_t               in_item,
    input  logic              out_free,
    output logic              result_valid,
    output out_t              result,
    output ram_cmd_t          next_cmd,
    output ram_cmd_t          prev_cmd,
    input  logic [ELEM_W-1:0] next_rdata,
    input  logic [ELEM_W-1:0] prev_rdata
);

    state_t state_reg, state_next;
    in_t    req_reg;

    logic [STAT_W-1:0] status_reg;
    logic [NUM_ELEMS-1:0] member_reg;
    logic [QSEL_W-1:0] owner_reg [NUM_ELEMS];
    logic [ELEM_W-1:0] head_reg [NUM_QUEUES];
    logic [LEN_W-1:0]  length_reg [NUM_QUEUES];

    logic [QSEL_W-1:0] q;
    logic [ELEM_W-1:0] e;
    logic              q_ok, e_ok;
    logic [LEN_W-1:0]  len_q;
    logic [ELEM_W-1:0] head_q;
    logic              member_e;
    logic              app_ok, app_empty, rem_ok, rem_single;

    logic              status_we;
    logic [STAT_W-1:0] status_wdata;
    logic              set_member, clr_member;
    logic              head_we;
    logic [ELEM_W-1:0] head_wdata;

    assign q        = req_reg.queue_sel;
    assign e        = req_reg.elem_index;
    assign q_ok     = ({1'b0, q} < (QSEL_W + 1)'(NUM_QUEUES));
    assign e_ok     = ({1'b0, e} < (ELEM_W + 1)'(NUM_ELEMS));
    assign len_q    = length_reg[q];
    assign head_q   = head_reg[q];
    assign member_e = member_reg[e];

    assign app_ok     = (req_reg.req_type == REQ_APPEND) && q_ok && e_ok && !member_e;
    assign app_empty  = (len_q == '0);
    assign rem_ok     = (req_reg.req_type == REQ_REMOVE) && q_ok && e_ok && (len_q != '0)
                        && member_e && (owner_reg[e] == q);
    assign rem_single = (len_q == LEN_W'(1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (app_ok && !app_empty)
                begin
                    state_next = S_APP_TAIL;
                end
                else if (rem_ok && !rem_single)
                begin
                    state_next = S_REM_LINK;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_APP_TAIL:
            begin
                state_next = S_APP_LINK;
            end
            S_APP_LINK:
            begin
                state_next = S_RESP;
            end
            S_REM_LINK:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        result_valid = 1'b0;
        status_we    = 1'b0;
        status_wdata = ST_DONE;
        set_member   = 1'b0;
        clr_member   = 1'b0;
        head_we      = 1'b0;
        head_wdata   = e;
        next_cmd     = '{we: 1'b0, waddr: e, wdata: e, raddr: e};
        prev_cmd     = '{we: 1'b0, waddr: e, wdata: e, raddr: e};
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_EXEC:
            begin
                status_we = 1'b1;
                if (req_reg.req_type == REQ_APPEND)
                begin
                    if (!app_ok)
                    begin
                        status_wdata = ST_QUEUED;
                    end
                    else if (app_empty)
                    begin
                        next_cmd.we = 1'b1;
                        prev_cmd.we = 1'b1;
                        head_we     = 1'b1;
                        set_member  = 1'b1;
                    end
                    else
                    begin
                        prev_cmd.raddr = head_q;
                    end
                end
                else if (req_reg.req_type == REQ_REMOVE)
                begin
                    if (!rem_ok)
                    begin
                        status_wdata = ST_ABSENT;
                    end
                    else if (rem_single)
                    begin
                        clr_member = 1'b1;
                    end
                end
            end
            S_APP_TAIL:
            begin
                next_cmd.we    = 1'b1;
                next_cmd.waddr = prev_rdata;
                prev_cmd.we    = 1'b1;
                prev_cmd.wdata = prev_rdata;
            end
            S_APP_LINK:
            begin
                next_cmd.we    = 1'b1;
                next_cmd.wdata = head_q;
                prev_cmd.we    = 1'b1;
                prev_cmd.waddr = head_q;
                set_member     = 1'b1;
            end
            S_REM_LINK:
            begin
                next_cmd.we    = 1'b1;
                next_cmd.waddr = prev_rdata;
                next_cmd.wdata = next_rdata;
                prev_cmd.we    = 1'b1;
                prev_cmd.waddr = next_rdata;
                prev_cmd.wdata = prev_rdata;
                head_we        = (head_q == e);
                head_wdata     = next_rdata;
                clr_member     = 1'b1;
            end
            S_RESP:
            begin
                result_valid = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result.status       = status_reg;
        result.queue_length = q_ok ? len_q : '0;
        result.head_valid   = q_ok && (len_q != '0);
        result.head_elem    = result.head_valid ? head_q : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            member_reg <= '0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                length_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (set_member)
            begin
                member_reg[e] <= 1'b1;
                length_reg[q] <= len_q + LEN_W'(1);
            end
            else if (clr_member)
            begin
                member_reg[e] <= 1'b0;
                length_reg[q] <= len_q - LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_item;
        end
        if (status_we)
        begin
            status_reg <= status_wdata;
        end
        if (set_member)
        begin
            owner_reg[e] <= q;
        end
        if (head_we)
        begin
            head_reg[q] <= head_wdata;
        end
    end

endmodule

// ===== rtl/linked_queue_manager_unit.sv =====
// ----------------------------------------------------------------------------
// Linked queue manager
// Circular doubly linked queues over a shared pool of element slots.
// ----------------------------------------------------------------------------
// Each request item takes one result item. A query, a rejected request, an
// append to an empty queue and a remove of a queue's only element go from
// the execute state straight to the result state; any other remove passes
// through the remove link state, any other append through the append tail
// and append link states. A new item is accepted once the controller is back
// in idle. The next and prev link memories have one write port each and a
// registered read: an append to a non-empty queue reads the tail link, then
// rewrites four links. The result register lets the next item be accepted
// while a result still waits to be taken. No clearing pass follows reset.
module linked_queue_manager_unit
    import lqm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_item,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_item
);

    ram_cmd_t          next_cmd, prev_cmd;
    logic [ELEM_W-1:0] next_rdata, prev_rdata;
    logic              result_valid;
    out_t              result;
    logic              out_free;
    logic              out_valid_reg;
    out_t              out_item_reg;

    assign out_free = !out_valid_reg || out_ready;

    lqm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_item      (in_item),
        .out_free     (out_free),
        .result_valid (result_valid),
        .result       (result),
        .next_cmd     (next_cmd),
        .prev_cmd     (prev_cmd),
        .next_rdata   (next_rdata),
        .prev_rdata   (prev_rdata)
    );

    lqm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (NUM_ELEMS)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_cmd.we),
        .waddr (next_cmd.waddr),
        .wdata (next_cmd.wdata),
        .raddr (next_cmd.raddr),
        .rdata (next_rdata)
    );

    lqm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (NUM_ELEMS)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_cmd.we),
        .waddr (prev_cmd.waddr),
        .wdata (prev_cmd.wdata),
        .raddr (prev_cmd.raddr),
        .rdata (prev_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_valid)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Linked queue manager testbench
// Drives append, remove, query and spare requests into the block, predicts each
// result from a private copy of the ring links, heads and queue lengths, and
// compares every result item field by field as it is taken.
// ----------------------------------------------------------------------------
module testbench;
    import lqm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 1900;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        in_t item;
        bit  hold;
    } pending_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t  in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_item;

    pending_t pending_reqs[$];
    out_t     expected_results[$];
    logic     in_accepted = 1'b0;
    int       error_count = 0;
    int       cycle_count = 0;

    // Predicted state of the queues.
    logic [ELEM_W-1:0] link_fwd[NUM_ELEMS] = '{default: '0};
    logic [ELEM_W-1:0] link_back[NUM_ELEMS] = '{default: '0};
    logic              slot_busy[NUM_ELEMS] = '{default: 1'b0};
    logic [QSEL_W-1:0] slot_queue[NUM_ELEMS] = '{default: '0};
    logic [ELEM_W-1:0] queue_head[NUM_QUEUES] = '{default: '0};
    logic [LEN_W-1:0]  queue_len[NUM_QUEUES] = '{default: '0};

    // Element ownership as seen by the stimulus generator, -1 when free.
    int slot_owner_gen[NUM_ELEMS] = '{default: -1};

    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_span = 0;

    linked_queue_manager_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #5 clk = ~clk;

    function automatic out_t apply_request(in_t req);
        out_t              res;
        logic [QSEL_W-1:0] q;
        logic [ELEM_W-1:0] e;
        logic [ELEM_W-1:0] h;
        logic [ELEM_W-1:0] t;
        logic [ELEM_W-1:0] p;
        logic [ELEM_W-1:0] n;
        res = '0;
        q = req.queue_sel;
        e = req.elem_index;
        res.status = ST_DONE;
        if (req.req_type == REQ_APPEND)
        begin
            if (slot_busy[e])
            begin
                res.status = ST_QUEUED;
            end
            else
            begin
                if (queue_len[q] == 0)
                begin
                    queue_head[q] = e;
                    link_fwd[e] = e;
                    link_back[e] = e;
                end
                else
                begin
                    h = queue_head[q];
                    t = link_back[h];
                    link_fwd[t] = e;
                    link_back[e] = t;
                    link_fwd[e] = h;
                    link_back[h] = e;
                end
                slot_busy[e] = 1'b1;
                slot_queue[e] = q;
                queue_len[q] = queue_len[q] + 1'b1;
            end
        end
        else if (req.req_type == REQ_REMOVE)
        begin
            if (queue_len[q] == 0 || !slot_busy[e] || slot_queue[e] != q)
            begin
                res.status = ST_ABSENT;
            end
            else
            begin
                if (queue_len[q] == 1)
                begin
                    queue_head[q] = '0;
                end
                else
                begin
                    p = link_back[e];
                    n = link_fwd[e];
                    if (queue_head[q] == e)
                    begin
                        queue_head[q] = n;
                    end
                    link_fwd[p] = n;
                    link_back[n] = p;
                end
                slot_busy[e] = 1'b0;
                queue_len[q] = queue_len[q] - 1'b1;
            end
        end
        res.queue_length = queue_len[q];
        if (queue_len[q] != 0)
        begin
            res.head_valid = 1'b1;
            res.head_elem = queue_head[q];
        end
        return res;
    endfunction

    task automatic report_error(string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
        begin
            report_error($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    task automatic queue_request(logic [REQ_W-1:0] req, int q, int e, bit hold);
        pending_t entry;
        entry.item.req_type = req;
        entry.item.queue_sel = QSEL_W'(q);
        entry.item.elem_index = ELEM_W'(e);
        entry.hold = hold;
        pending_reqs.push_back(entry);
        if (req == REQ_APPEND && slot_owner_gen[e] < 0)
        begin
            slot_owner_gen[e] = q;
        end
        else if (req == REQ_REMOVE && slot_owner_gen[e] == q)
        begin
            slot_owner_gen[e] = -1;
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** linked_queue_manager_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin : monitor
        out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_error("result item arrived with no request outstanding");
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 8'(out_item.status), 8'(want.status));
                    check_field("queue_length", 8'(out_item.queue_length),
                                8'(want.queue_length));
                    check_field("head_elem", 8'(out_item.head_elem), 8'(want.head_elem));
                    check_field("head_valid", 8'(out_item.head_valid),
                                8'(want.head_valid));
                end
            end
            if (in_valid && in_ready)
            begin
                expected_results.push_back(apply_request(in_item));
            end
            in_accepted <= in_valid && in_ready;
        end
        else
        begin
            in_accepted <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : driver
        pending_t entry;
        if (rst_n)
        begin
            if (in_valid && !in_accepted)
            begin
                in_valid <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].hold && expected_results.size() != 0))
            begin
                entry = pending_reqs.pop_front();
                in_valid <= 1'b1;
                in_item <= entry.item;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : receiver
        if (rst_n)
        begin
            if (stall_span == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_span <= $urandom_range(20, 200);
            end
            else
            begin
                stall_span <= stall_span - 1;
            end
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ($urandom_range(0, 7) == 0);
                default: out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    initial
    begin : stimulus
        int favored_q;
        int pick;
        int qs;
        int es;
        int append_share;
        int remove_share;
        bit hold;
        int candidates[$];

        // Empty queues, the spare request code and a remove from an empty queue.
        queue_request(REQ_QUERY, 0, 9, 1'b0);
        queue_request(REQ_SPARE, 3, 4, 1'b0);
        queue_request(REQ_REMOVE, 2, 5, 1'b0);
        // Appends, with rejected repeats of an element already queued, here and elsewhere.
        queue_request(REQ_APPEND, 0, 0, 1'b0);
        queue_request(REQ_APPEND, 0, 0, 1'b0);
        queue_request(REQ_APPEND, 1, 0, 1'b0);
        queue_request(REQ_APPEND, 1, 15, 1'b0);
        // Remove of an element held by another queue, then of a free element.
        queue_request(REQ_REMOVE, 1, 0, 1'b0);
        queue_request(REQ_REMOVE, 0, 7, 1'b0);
        // Removes from the middle, the head, the tail and the only element.
        queue_request(REQ_APPEND, 0, 1, 1'b0);
        queue_request(REQ_APPEND, 0, 2, 1'b0);
        queue_request(REQ_APPEND, 0, 3, 1'b0);
        queue_request(REQ_REMOVE, 0, 2, 1'b0);
        queue_request(REQ_REMOVE, 0, 0, 1'b0);
        queue_request(REQ_REMOVE, 0, 3, 1'b0);
        queue_request(REQ_REMOVE, 0, 1, 1'b0);
        queue_request(REQ_REMOVE, 1, 15, 1'b0);
        queue_request(REQ_APPEND, 3, 15, 1'b0);
        queue_request(REQ_APPEND, 3, 8, 1'b0);
        queue_request(REQ_REMOVE, 3, 15, 1'b0);
        queue_request(REQ_SPARE, 3, 0, 1'b0);
        queue_request(REQ_REMOVE, 3, 8, 1'b1);
        queue_request(REQ_QUERY, 2, 15, 1'b0);

        favored_q = 0;
        append_share = 55;
        remove_share = 80;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 150 == 0)
            begin
                favored_q = $urandom_range(0, NUM_QUEUES - 1);
                append_share = ((i / 150) % 2 == 0) ? 55 : 25;
                remove_share = 80;
            end
            hold = (i == 600 || i == 1300 || $urandom_range(0, 199) == 0);
            pick = $urandom_range(0, 99);
            qs = ($urandom_range(0, 9) < 6) ? favored_q : $urandom_range(0, NUM_QUEUES - 1);
            es = $urandom_range(0, NUM_ELEMS - 1);
            candidates.delete();
            if (pick < append_share)
            begin
                foreach (slot_owner_gen[k])
                begin
                    if (slot_owner_gen[k] < 0)
                    begin
                        candidates.push_back(k);
                    end
                end
                if (candidates.size() != 0 && $urandom_range(0, 4) != 0)
                begin
                    es = candidates[$urandom_range(0, candidates.size() - 1)];
                end
                queue_request(REQ_APPEND, qs, es, hold);
            end
            else if (pick < remove_share)
            begin
                foreach (slot_owner_gen[k])
                begin
                    if (slot_owner_gen[k] == qs)
                    begin
                        candidates.push_back(k);
                    end
                end
                if (candidates.size() != 0 && $urandom_range(0, 6) != 0)
                begin
                    es = candidates[$urandom_range(0, candidates.size() - 1)];
                end
                queue_request(REQ_REMOVE, qs, es, hold);
            end
            else if (pick < 90)
            begin
                queue_request(REQ_QUERY, qs, es, hold);
            end
            else if (pick < 94)
            begin
                queue_request(REQ_SPARE, qs, es, hold);
            end
            else
            begin
                queue_request(REQ_W'($urandom_range(0, 3)), qs, es, hold);
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("** linked_queue_manager_unit: PASSED **");
        end
        else
        begin
            $display("** linked_queue_manager_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lqm_pkg.sv
rtl/lqm_ram.sv
rtl/lqm_ctrl.sv
rtl/linked_queue_manager_unit.sv
tb/sv/testbench.sv
